/* rtl/lbae_pkg.sv */
// ----------------------------------------------------------------------------
// LED breathe animation engine package
// Shared types, codes and constants for the animation engine.
// ----------------------------------------------------------------------------
package lbae_pkg;

    localparam int LED_COUNT_DEF = 10;

    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_MODE       = 2'd1;
    localparam logic [1:0] REG_FLOOR      = 2'd2;
    localparam logic [1:0] REG_CEILING    = 2'd3;

    localparam logic [2:0] MODE_STATIC  = 3'd0;
    localparam logic [2:0] MODE_BREATHE1 = 3'd1;
    localparam logic [2:0] MODE_BREATHE2 = 3'd2;
    localparam logic [2:0] MODE_BREATHE3 = 3'd3;
    localparam logic [2:0] MODE_CYCLE   = 3'd4;

    localparam logic [1:0] COLOUR_NONE  = 2'd0;
    localparam logic [1:0] COLOUR_BLUE  = 2'd1;
    localparam logic [1:0] COLOUR_GREEN = 2'd2;
    localparam logic [1:0] COLOUR_RED   = 2'd3;

    localparam logic [7:0] LEVEL_MASK   = 8'h1F;
    localparam logic [7:0] HEADER_BITS  = 8'hE0;
    localparam logic [7:0] FULL_LEVEL   = 8'h6F;
    localparam logic [7:0] HALF_LEVEL   = 8'h3F;
    localparam logic [7:0] CYCLE_WRAP   = 8'd120;
    localparam logic [7:0] CYCLE_RED    = 8'd80;
    localparam logic [7:0] CYCLE_GREEN  = 8'd40;

    typedef enum logic [2:0] {
        ACT_KEEP,
        ACT_LOAD_STATIC,
        ACT_LOAD_RED,
        ACT_LOAD_YELLOW,
        ACT_LOAD_ALT,
        ACT_BREATHE,
        ACT_CYCLE
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic [7:0] global_byte;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [2:0] dir;
    } cell_t;

    typedef struct packed {
        action_t    action;
        logic [1:0] dir_sel;
        logic [7:0] brightness;
        logic [4:0] floor_level;
        logic [4:0] ceiling_level;
        logic [1:0] colour;
    } update_ctl_t;

    localparam cell_t CELL_RESET = '{global_byte: 8'h00, blue: 8'h00, green: 8'h00,
                                     red: 8'h00, dir: 3'b111};

endpackage

/* rtl/lbae_cell.sv */
// ----------------------------------------------------------------------------
// LED frame cell
// Holds the frame and breathe direction bits of one LED in the ring.
// ----------------------------------------------------------------------------
module lbae_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  lbae_pkg::cell_t d,
    output lbae_pkg::cell_t q
);

    lbae_pkg::cell_t cell_reg;
    lbae_pkg::cell_t cell_next;

    always_comb
    begin
        cell_next = shift ? d : cell_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= lbae_pkg::CELL_RESET;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign q = cell_reg;

endmodule

/* rtl/lbae_update.sv */
// ----------------------------------------------------------------------------
// LED frame update
// Computes the new frame of the LED leaving the head of the ring.
// ----------------------------------------------------------------------------
module lbae_update (
    input  lbae_pkg::cell_t       head,
    input  logic                  odd,
    input  lbae_pkg::update_ctl_t ctl,
    output lbae_pkg::cell_t       upd
);

    logic [7:0] load_level;
    logic [7:0] level_sum;
    logic [8:0] top;
    logic [8:0] bottom;
    logic [8:0] level;
    logic       dir_bit;
    logic       up;
    logic [2:0] dir_new;

    always_comb
    begin
        level_sum  = ctl.brightness + {3'd0, ctl.floor_level};
        load_level = (level_sum & lbae_pkg::LEVEL_MASK) | lbae_pkg::HEADER_BITS;
        top        = {1'b0, ctl.brightness} + {4'd0, ctl.ceiling_level};
        bottom     = {1'b0, ctl.brightness} + {4'd0, ctl.floor_level};
        level      = {1'b0, head.global_byte & lbae_pkg::LEVEL_MASK};
        dir_bit    = head.dir[ctl.dir_sel];
        dir_new    = head.dir;
        if (level >= top)
        begin
            up = 1'b0;
            dir_new[ctl.dir_sel] = 1'b0;
        end
        else if (level <= bottom)
        begin
            up = 1'b1;
            dir_new[ctl.dir_sel] = 1'b1;
        end
        else
        begin
            up = dir_bit;
        end

        upd = head;
        case (ctl.action)
            lbae_pkg::ACT_LOAD_STATIC:
            begin
                upd.global_byte = load_level;
                upd.blue        = 8'h00;
                upd.green       = odd ? lbae_pkg::FULL_LEVEL : 8'h00;
                upd.red         = lbae_pkg::FULL_LEVEL;
            end
            lbae_pkg::ACT_LOAD_RED:
            begin
                upd.global_byte = load_level;
                upd.blue        = 8'h00;
                upd.green       = 8'h00;
                upd.red         = lbae_pkg::HALF_LEVEL;
            end
            lbae_pkg::ACT_LOAD_YELLOW:
            begin
                upd.global_byte = load_level;
                upd.blue        = 8'h00;
                upd.green       = lbae_pkg::HALF_LEVEL;
                upd.red         = lbae_pkg::HALF_LEVEL;
            end
            lbae_pkg::ACT_LOAD_ALT:
            begin
                upd.global_byte = load_level;
                upd.blue        = 8'h00;
                upd.green       = odd ? lbae_pkg::HALF_LEVEL : 8'h00;
                upd.red         = lbae_pkg::HALF_LEVEL;
            end
            lbae_pkg::ACT_BREATHE:
            begin
                upd.global_byte = up ? head.global_byte + 8'd1 : head.global_byte - 8'd1;
                upd.dir         = dir_new;
            end
            lbae_pkg::ACT_CYCLE:
            begin
                upd.global_byte = load_level;
                upd.blue  = (ctl.colour == lbae_pkg::COLOUR_BLUE)  ? lbae_pkg::FULL_LEVEL : 8'h00;
                upd.green = (ctl.colour == lbae_pkg::COLOUR_GREEN) ? lbae_pkg::FULL_LEVEL : 8'h00;
                upd.red   = (ctl.colour == lbae_pkg::COLOUR_RED)   ? lbae_pkg::FULL_LEVEL : 8'h00;
            end
            default:
            begin
                upd = head;
            end
        endcase
    end

endmodule

/* rtl/led_breathe_animation_engine_unit.sv */
// ----------------------------------------------------------------------------
// LED breathe animation engine
// Turns animation ticks into one frame per LED for a serial LED string.
// ----------------------------------------------------------------------------
// Each accepted tick produces LED_COUNT frame transfers, LED 0 first, with
// last_led set on the final one. The LED frames live in a ring of cells that
// rotates by one cell per cycle while a tick runs and the output is not
// stalled; the frame leaving the head is updated, presented on the output and
// written back at the tail. Further ticks stall until the last LED is sent.
// Configuration must be written only between ticks; the block does not check.
module led_breathe_animation_engine_unit #(
    parameter int LED_COUNT = lbae_pkg::LED_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] led_index,
    output logic [7:0] global_byte,
    output logic [7:0] blue,
    output logic [7:0] green,
    output logic [7:0] red,
    output logic       last_led,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    lbae_pkg::state_t   state_reg, state_next;
    lbae_pkg::action_t  action_reg, action_next;
    logic [7:0]         brightness_reg;
    logic [2:0]         mode_reg;
    logic [4:0]         floor_reg;
    logic [4:0]         ceiling_reg;
    logic [7:0]         counter_reg, counter_next;
    logic [1:0]         colour_reg, colour_next;
    logic [5:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    lbae_pkg::cell_t    out_reg;
    logic [5:0]         out_idx_reg;
    logic               out_last_reg;
    logic               accept;
    logic               advance;
    logic               is_last;
    lbae_pkg::update_ctl_t ctl;
    lbae_pkg::cell_t    upd;
    lbae_pkg::cell_t    ring [LED_COUNT];

    assign accept  = (state_reg == lbae_pkg::ST_IDLE) && in_valid;
    assign advance = (state_reg == lbae_pkg::ST_RUN) && (!out_valid_reg || !out_stall);
    assign is_last = (idx_reg == 6'(LED_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 8'd0;
            mode_reg       <= lbae_pkg::MODE_STATIC;
            floor_reg      <= 5'd1;
            ceiling_reg    <= 5'd30;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbae_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_data;
                lbae_pkg::REG_MODE:       mode_reg       <= cfg_data[2:0];
                lbae_pkg::REG_FLOOR:      floor_reg      <= cfg_data[4:0];
                lbae_pkg::REG_CEILING:    ceiling_reg    <= cfg_data[4:0];
                default:                  brightness_reg <= brightness_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        action_next    = action_reg;
        counter_next   = counter_reg;
        colour_next    = colour_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            lbae_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lbae_pkg::ST_RUN;
                    idx_next   = 6'd0;
                    case (mode_reg)
                        lbae_pkg::MODE_STATIC:
                        begin
                            action_next = lbae_pkg::ACT_LOAD_STATIC;
                        end
                        lbae_pkg::MODE_BREATHE1:
                        begin
                            action_next = restart ? lbae_pkg::ACT_LOAD_RED
                                                  : lbae_pkg::ACT_BREATHE;
                        end
                        lbae_pkg::MODE_BREATHE2:
                        begin
                            action_next = restart ? lbae_pkg::ACT_LOAD_YELLOW
                                                  : lbae_pkg::ACT_BREATHE;
                        end
                        lbae_pkg::MODE_BREATHE3:
                        begin
                            action_next = restart ? lbae_pkg::ACT_LOAD_ALT
                                                  : lbae_pkg::ACT_BREATHE;
                        end
                        lbae_pkg::MODE_CYCLE:
                        begin
                            if (restart)
                            begin
                                action_next  = lbae_pkg::ACT_LOAD_STATIC;
                                counter_next = 8'd0;
                            end
                            else
                            begin
                                action_next = lbae_pkg::ACT_CYCLE;
                                if (counter_reg > lbae_pkg::CYCLE_WRAP)
                                begin
                                    counter_next = 8'd1;
                                end
                                else
                                begin
                                    counter_next = counter_reg + 8'd1;
                                    if (counter_reg > lbae_pkg::CYCLE_RED)
                                    begin
                                        colour_next = lbae_pkg::COLOUR_RED;
                                    end
                                    else if (counter_reg > lbae_pkg::CYCLE_GREEN)
                                    begin
                                        colour_next = lbae_pkg::COLOUR_GREEN;
                                    end
                                    else
                                    begin
                                        colour_next = lbae_pkg::COLOUR_BLUE;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            action_next = lbae_pkg::ACT_KEEP;
                        end
                    endcase
                end
            end
            lbae_pkg::ST_RUN:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 6'd1;
                    if (is_last)
                    begin
                        state_next = lbae_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lbae_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbae_pkg::ST_IDLE;
            action_reg    <= lbae_pkg::ACT_KEEP;
            counter_reg   <= 8'd1;
            colour_reg    <= lbae_pkg::COLOUR_NONE;
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            action_reg    <= action_next;
            counter_reg   <= counter_next;
            colour_reg    <= colour_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg      <= upd;
            out_idx_reg  <= idx_reg;
            out_last_reg <= is_last;
        end
    end

    always_comb
    begin
        ctl.action        = action_reg;
        ctl.dir_sel       = mode_reg[1:0] - 2'd1;
        ctl.brightness    = brightness_reg;
        ctl.floor_level   = floor_reg;
        ctl.ceiling_level = ceiling_reg;
        ctl.colour        = colour_reg;
    end

    lbae_update u_update (
        .head (ring[0]),
        .odd  (idx_reg[0]),
        .ctl  (ctl),
        .upd  (upd)
    );

    for (genvar i = 0; i < LED_COUNT; i++)
    begin : g_ring
        if (i == LED_COUNT - 1)
        begin : g_tail
            lbae_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (advance),
                .d     (upd),
                .q     (ring[i])
            );
        end
        else
        begin : g_body
            lbae_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (advance),
                .d     (ring[i + 1]),
                .q     (ring[i])
            );
        end
    end

    assign in_stall    = (state_reg != lbae_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign led_index   = out_idx_reg;
    assign global_byte = out_reg.global_byte;
    assign blue        = out_reg.blue;
    assign green       = out_reg.green;
    assign red         = out_reg.red;
    assign last_led    = out_last_reg;

endmodule
